// File: hw/rtl/nau_pkg.sv
// Shared types, constants and table functions for the neural activation unit.
`timescale 1ns / 1ps
package nau_pkg;

	localparam int FRAC_BITS = 10;
	localparam int SEG_BITS  = 6;
	localparam int TBL_LEN   = (1 << SEG_BITS) + 1;
	localparam int IDX_W     = SEG_BITS + 1;
	localparam int ENT_W     = FRAC_BITS + 1;

	localparam int ONE_Q    = 1 << FRAC_BITS;
	localparam int ONE_SQ   = 1 << (2 * FRAC_BITS);
	localparam int MARGIN_Q = ((3 << FRAC_BITS) + 5) / 10;

	// segment shifts: tanh spans 8, sigmoid 16, exp 16 at 2F fraction bits
	localparam int TANH_SH  = 3 + FRAC_BITS - SEG_BITS;
	localparam int SIG_SH   = 4 + FRAC_BITS - SEG_BITS;
	localparam int EXP_SH   = 4 + 2 * FRAC_BITS - SEG_BITS;
	localparam int TANH_LIM = 8 << FRAC_BITS;
	localparam int SIG_LIM  = 16 << FRAC_BITS;
	localparam int EXP_LIM  = 1 << (4 + 2 * FRAC_BITS);

	// segment widths of the tables in real units
	localparam real TANH_STEP = 8.0 / (1 << SEG_BITS);
	localparam real SPAN_STEP = 16.0 / (1 << SEG_BITS);

	typedef enum logic [3:0] {
		FK_ZERO       = 4'd0,
		FK_LINEAR     = 4'd1,
		FK_TANH       = 4'd2,
		FK_RELU       = 4'd3,
		FK_SYMM_RELU  = 4'd4,
		FK_TANH_SHIFT = 4'd5,
		FK_SOFTSIGN   = 4'd6,
		FK_SIGMOID    = 4'd7,
		FK_GAUSS      = 4'd8,
		FK_GAUSS_C    = 4'd9
	} func_kind_t;

	typedef logic [ENT_W-1:0] tab_t [0:TBL_LEN-1];

	function automatic tab_t build_tanh_tab();
		tab_t t;
		real p;
		for (int k = 0; k < TBL_LEN; k++) begin
			p = real'(k) * TANH_STEP;
			t[k] = ENT_W'($rtoi($tanh(p) * real'(ONE_Q) + 0.5));
		end
		return t;
	endfunction

	// logistic written through tanh: s(p) = (1 + tanh(p/2)) / 2
	function automatic tab_t build_sig_tab();
		tab_t t;
		real p;
		for (int k = 0; k < TBL_LEN; k++) begin
			p = real'(k) * SPAN_STEP;
			t[k] = ENT_W'($rtoi(real'(ONE_Q) * 0.5 * (1.0 + $tanh(0.5 * p)) + 0.5));
		end
		return t;
	endfunction

	function automatic tab_t build_exp_tab();
		tab_t t;
		real p;
		for (int k = 0; k < TBL_LEN; k++) begin
			p = real'(k) * SPAN_STEP;
			t[k] = ENT_W'($rtoi($exp(-p) * real'(ONE_Q) + 0.5));
		end
		return t;
	endfunction

	localparam tab_t TANH_TAB = build_tanh_tab();
	localparam tab_t SIG_TAB  = build_sig_tab();
	localparam tab_t EXP_TAB  = build_exp_tab();

endpackage

// File: hw/rtl/neural_activation_unit.sv
// Top level of the neural activation unit: six-stage activation pipeline.
`timescale 1ns / 1ps
// One signed Q5.10 value enters per cycle and one Q5.10 result leaves per cycle. Each request
// passes six pipeline registers (square, table fetch, interpolation multiply,
// interpolate/divide finish, derivative multiply, round and saturate); the first loads at the
// accepting edge, and the result shows on result_value once the sixth has loaded. Stages
// advance independently, so bubbles close up and in_ready only drops when every stage holds
// a request and out_ready is low. Softsign uses a restoring divider spread over three stages.
// function_kind may only be written while no request is in flight.
module neural_activation_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [3:0]          cfg_wr_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                opcode,
	input  logic signed [15:0]  operand_value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [15:0]  result_value,
	output logic                saturated
);
	import nau_pkg::*;

	typedef enum logic [1:0] {PM_PASS, PM_RND, PM_RND_X72, PM_RND_NX72} post_mode_t;

	// restoring division steps, quotient bits top down to top-cnt+1
	function automatic logic [38:0] div_steps(input logic [27:0] rem_i, input logic [10:0] q_i,
			input logic [17:0] den_i, input int top, input int cnt);
		logic [27:0] rem;
		logic [27:0] sub;
		logic [10:0] q;
		rem = rem_i;
		q   = q_i;
		for (int j = 0; j < cnt; j++) begin
			sub = 28'(den_i) << (top - j);
			if (rem >= sub) begin
				rem = rem - sub;
				q[top - j] = 1'b1;
			end
		end
		return {q, rem};
	endfunction

	logic [3:0] kind_q;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en_1, en_2, en_3, en_4, en_5, en_6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) kind_q <= FK_LINEAR;
		else if (cfg_wr_en) kind_q <= cfg_wr_data;
	end

	assign en_6 = !v_s6 || out_ready;
	assign en_5 = !v_s5 || en_6;
	assign en_4 = !v_s4 || en_5;
	assign en_3 = !v_s3 || en_4;
	assign en_2 = !v_s2 || en_3;
	assign en_1 = !v_s1 || en_2;
	assign in_ready = en_1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
		end else begin
			if (en_1) v_s1 <= in_valid;
			if (en_2) v_s2 <= v_s1;
			if (en_3) v_s3 <= v_s2;
			if (en_4) v_s4 <= v_s3;
			if (en_5) v_s5 <= v_s4;
			if (en_6) v_s6 <= v_s5;
		end
	end

	// ---------------- stage 1: magnitudes and square
	logic signed [16:0] x_ext, xm;
	logic [16:0] ax, am;
	logic signed [31:0] sq_full;

	always_comb begin
		x_ext   = {operand_value[15], operand_value};
		ax      = x_ext[16] ? 17'(-x_ext) : 17'(x_ext);
		xm      = x_ext - 17'(MARGIN_Q);
		am      = xm[16] ? 17'(-xm) : 17'(xm);
		sq_full = operand_value * operand_value;
	end

	logic signed [15:0] x_s1;
	logic d_s1;
	logic [3:0] kind_s1;
	logic [16:0] a_s1, targ_s1;
	logic tneg_s1;
	logic [30:0] sq_s1;

	always_ff @(posedge clk) begin
		if (en_1) begin
			x_s1    <= operand_value;
			d_s1    <= opcode;
			kind_s1 <= kind_q;
			a_s1    <= ax;
			targ_s1 <= (kind_q == FK_TANH_SHIFT) ? am : ax;
			tneg_s1 <= (kind_q == FK_TANH_SHIFT) ? xm[16] : x_ext[16];
			sq_s1   <= sq_full[30:0];
		end
	end

	// ---------------- stage 2: table fetch, polynomial derivatives, divider head
	logic [35:0] u;
	logic [SEG_BITS-1:0] idx;
	logic [IDX_W-1:0] idx0, idx1;
	logic [EXP_SH-1:0] fr;
	logic beyond, bone, lneg;
	logic [ENT_W-1:0] e0, e1;
	logic signed [32:0] wide;
	logic [17:0] den, dd;
	logic [27:0] num;
	logic [38:0] dv2;

	always_comb begin
		u      = (36'(sq_s1) << 5) + (36'(sq_s1) << 2);
		idx    = '0;
		fr     = '0;
		beyond = 1'b1;
		bone   = 1'b0;
		lneg   = 1'b0;
		case (kind_s1) inside
			FK_TANH, FK_TANH_SHIFT: begin
				idx    = targ_s1[TANH_SH +: SEG_BITS];
				fr     = EXP_SH'(targ_s1[TANH_SH-1:0]) << (EXP_SH - TANH_SH);
				beyond = targ_s1 >= 17'(TANH_LIM);
				bone   = 1'b1;
				lneg   = tneg_s1;
			end
			FK_SIGMOID: begin
				idx    = a_s1[SIG_SH +: SEG_BITS];
				fr     = EXP_SH'(a_s1[SIG_SH-1:0]) << (EXP_SH - SIG_SH);
				beyond = a_s1 >= 17'(SIG_LIM);
				bone   = 1'b1;
				lneg   = x_s1[15];
			end
			FK_GAUSS, FK_GAUSS_C: begin
				idx    = u[EXP_SH +: SEG_BITS];
				fr     = u[EXP_SH-1:0];
				beyond = u >= 36'(EXP_LIM);
			end
			default: ;
		endcase
		idx0 = {1'b0, idx};
		idx1 = idx0 + IDX_W'(1);
		case (kind_s1) inside
			FK_TANH, FK_TANH_SHIFT: begin
				e0 = TANH_TAB[idx0];
				e1 = TANH_TAB[idx1];
			end
			FK_SIGMOID: begin
				e0 = SIG_TAB[idx0];
				e1 = SIG_TAB[idx1];
			end
			default: begin
				e0 = EXP_TAB[idx0];
				e1 = EXP_TAB[idx1];
			end
		endcase

		case (kind_s1)
			FK_TANH:       wide = 33'(ONE_SQ) - 33'(sq_s1);
			FK_TANH_SHIFT: wide = 33'(MARGIN_Q << FRAC_BITS) + 33'(ONE_SQ) - 33'(sq_s1);
			FK_SOFTSIGN:   wide = 33'(sq_s1) + 33'(ONE_SQ) - (33'(a_s1) << 11);
			default:       wide = '0;
		endcase

		// softsign: round(a*1024/(1024+a)) = floor((2048a + den) / (2 den))
		den = 18'(a_s1) + 18'(ONE_Q);
		dd  = den << 1;
		num = (28'(a_s1) << 11) + 28'(den);
		dv2 = div_steps(num, 11'd0, dd, 10, 4);
	end

	logic signed [15:0] x_s2;
	logic d_s2;
	logic [3:0] kind_s2;
	logic [ENT_W-1:0] e0_s2, e1_s2;
	logic [EXP_SH-1:0] fr_s2;
	logic beyond_s2, bone_s2, lneg_s2;
	logic signed [32:0] wide_s2;
	logic [27:0] rem_s2;
	logic [10:0] q_s2;
	logic [17:0] dd_s2;

	always_ff @(posedge clk) begin
		if (en_2) begin
			x_s2      <= x_s1;
			d_s2      <= d_s1;
			kind_s2   <= kind_s1;
			e0_s2     <= e0;
			e1_s2     <= e1;
			fr_s2     <= fr;
			beyond_s2 <= beyond;
			bone_s2   <= bone;
			lneg_s2   <= lneg;
			wide_s2   <= wide;
			q_s2      <= dv2[38:28];
			rem_s2    <= dv2[27:0];
			dd_s2     <= dd;
		end
	end

	// ---------------- stage 3: interpolation multiply, divider middle
	logic [ENT_W-1:0] diff;
	logic up;
	logic [28:0] prod;
	logic [38:0] dv3;

	always_comb begin
		up   = e1_s2 >= e0_s2;
		diff = up ? (e1_s2 - e0_s2) : (e0_s2 - e1_s2);
		prod = 29'(diff) * 29'(fr_s2);
		dv3  = div_steps(rem_s2, q_s2, dd_s2, 6, 4);
	end

	logic signed [15:0] x_s3;
	logic d_s3;
	logic [3:0] kind_s3;
	logic [ENT_W-1:0] e0_s3;
	logic [28:0] prod_s3;
	logic up_s3, beyond_s3, bone_s3, lneg_s3;
	logic signed [32:0] wide_s3;
	logic [27:0] rem_s3;
	logic [10:0] q_s3;
	logic [17:0] dd_s3;

	always_ff @(posedge clk) begin
		if (en_3) begin
			x_s3      <= x_s2;
			d_s3      <= d_s2;
			kind_s3   <= kind_s2;
			e0_s3     <= e0_s2;
			prod_s3   <= prod;
			up_s3     <= up;
			beyond_s3 <= beyond_s2;
			bone_s3   <= bone_s2;
			lneg_s3   <= lneg_s2;
			wide_s3   <= wide_s2;
			q_s3      <= dv3[38:28];
			rem_s3    <= dv3[27:0];
			dd_s3     <= dd_s2;
		end
	end

	// ---------------- stage 4: finish interpolation and division
	logic [ENT_W-1:0] corr, y;
	logic [28:0] prod_r;
	logic signed [11:0] fv, ss;
	logic [38:0] dv4;

	always_comb begin
		prod_r = prod_s3 + 29'(1 << (EXP_SH - 1));
		corr   = ENT_W'(prod_r >> EXP_SH);
		y      = up_s3 ? (e0_s3 + corr) : (e0_s3 - corr);
		if (beyond_s3) y = bone_s3 ? ENT_W'(ONE_Q) : '0;
		case (kind_s3) inside
			FK_TANH, FK_TANH_SHIFT: fv = lneg_s3 ? -12'(y) : 12'(y);
			FK_SIGMOID:             fv = lneg_s3 ? 12'(ONE_Q) - 12'(y) : 12'(y);
			FK_GAUSS:               fv = 12'(y);
			FK_GAUSS_C:             fv = 12'(ONE_Q) - 12'(y);
			default:                fv = '0;
		endcase
		dv4 = div_steps(rem_s3, q_s3, dd_s3, 2, 3);
		ss  = x_s3[15] ? -12'(dv4[38:28]) : 12'(dv4[38:28]);
	end

	logic signed [15:0] x_s4;
	logic d_s4;
	logic [3:0] kind_s4;
	logic signed [11:0] fv_s4, ss_s4;
	logic signed [32:0] wide_s4;

	always_ff @(posedge clk) begin
		if (en_4) begin
			x_s4    <= x_s3;
			d_s4    <= d_s3;
			kind_s4 <= kind_s3;
			fv_s4   <= fv;
			ss_s4   <= ss;
			wide_s4 <= wide_s3;
		end
	end

	// ---------------- stage 5: derivative multiply and result selection
	logic signed [16:0] ma;
	logic signed [11:0] mb;
	logic signed [28:0] mp;
	logic signed [32:0] pv;
	post_mode_t pm;

	always_comb begin
		ma = (kind_s4 == FK_SIGMOID) ? 17'(fv_s4) : 17'(x_s4);
		mb = (kind_s4 == FK_SIGMOID) ? 12'(ONE_Q) - fv_s4 : fv_s4;
		mp = 29'(ma * mb);
		pm = PM_PASS;
		pv = '0;
		case (kind_s4)
			FK_LINEAR: pv = d_s4 ? 33'(ONE_Q) : 33'(x_s4);
			FK_TANH, FK_TANH_SHIFT: begin
				pv = d_s4 ? wide_s4 : 33'(fv_s4);
				pm = d_s4 ? PM_RND : PM_PASS;
			end
			FK_RELU: begin
				if (x_s4 > 16'sd0) pv = d_s4 ? 33'(ONE_Q) : 33'(x_s4);
			end
			FK_SYMM_RELU: begin
				if (x_s4 > 16'(MARGIN_Q))
					pv = d_s4 ? 33'(ONE_Q) : 33'(x_s4) - 33'(MARGIN_Q);
				else if (x_s4 < -16'(MARGIN_Q))
					pv = d_s4 ? 33'(ONE_Q) : 33'(x_s4) + 33'(MARGIN_Q);
			end
			FK_SOFTSIGN: begin
				pv = d_s4 ? wide_s4 : 33'(ss_s4);
				pm = d_s4 ? PM_RND : PM_PASS;
			end
			FK_SIGMOID: begin
				pv = d_s4 ? 33'(mp) : 33'(fv_s4);
				pm = d_s4 ? PM_RND : PM_PASS;
			end
			FK_GAUSS: begin
				pv = d_s4 ? 33'(mp) : 33'(fv_s4);
				pm = d_s4 ? PM_RND_NX72 : PM_PASS;
			end
			FK_GAUSS_C: begin
				pv = d_s4 ? 33'(mp) : 33'(fv_s4);
				pm = d_s4 ? PM_RND_X72 : PM_PASS;
			end
			default: ;
		endcase
	end

	logic signed [32:0] pv_s5;
	post_mode_t pm_s5;

	always_ff @(posedge clk) begin
		if (en_5) begin
			pv_s5 <= pv;
			pm_s5 <= pm;
		end
	end

	// ---------------- stage 6: scale, round half away from zero, saturate
	logic signed [36:0] t, r;
	logic [36:0] mag;
	logic signed [15:0] res;
	logic sat;

	always_comb begin
		case (pm_s5)
			PM_RND_X72:  t = (37'(pv_s5) <<< 6) + (37'(pv_s5) <<< 3);
			PM_RND_NX72: t = -((37'(pv_s5) <<< 6) + (37'(pv_s5) <<< 3));
			default:     t = 37'(pv_s5);
		endcase
		mag = t[36] ? 37'(-t) : 37'(t);
		mag = (mag + 37'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		r   = (pm_s5 == PM_PASS) ? t : (t[36] ? -37'(mag) : 37'(mag));
		sat = 1'b1;
		if (r > 37'sd32767) res = 16'sh7fff;
		else if (r < -37'sd32768) res = 16'sh8000;
		else begin
			res = r[15:0];
			sat = 1'b0;
		end
	end

	logic signed [15:0] res_s6;
	logic sat_s6;

	always_ff @(posedge clk) begin
		if (en_6) begin
			res_s6 <= res;
			sat_s6 <= sat;
		end
	end

	assign out_valid    = v_s6;
	assign result_value = res_s6;
	assign saturated    = sat_s6;

	// ---------------- checks
	a_sat_clamps: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 && sat_s6 |-> (res_s6 == 16'sh7fff || res_s6 == 16'sh8000))
		else $error("saturated flag without clamped value");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 && !out_ready |=> v_s6 && $stable(res_s6) && $stable(sat_s6))
		else $error("output request changed while stalled");

	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && !out_ready))
		else $error("input blocked while pipeline has a bubble");

	a_softsign_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && kind_s4 == FK_SOFTSIGN |-> (ss_s4 <= 12'sd1024 && ss_s4 >= -12'sd1024))
		else $error("softsign quotient out of range");

endmodule

// File: dv/neural_activation_unit_test.sv
// Self-checking testbench for the neural activation unit: all kinds, both opcodes, random flow.
`timescale 1ns / 1ps
module neural_activation_unit_test;
	import nau_pkg::*;

	class act_scoreboard;
		logic [3:0] kind = FK_LINEAR;
		longint tanh_pts [0:64];
		longint sig_pts [0:64];
		longint exp_pts [0:64];
		logic signed [15:0] want_val [$];
		bit want_sat [$];
		int errors = 0;
		int noted = 0;
		int checked = 0;

		function new();
			real p;
			for (int k = 0; k <= 64; k++) begin
				p = real'(k) * 8.0 / 64.0;
				tanh_pts[k] = $rtoi($tanh(p) * 1024.0 + 0.5);
				p = real'(k) * 16.0 / 64.0;
				sig_pts[k] = $rtoi(1024.0 / (1.0 + $exp(-p)) + 0.5);
				exp_pts[k] = $rtoi($exp(-p) * 1024.0 + 0.5);
			end
		endfunction

		// piecewise-linear table read; which selects tanh, sigmoid or exp
		function longint interp(int which, int span_bits, longint a, longint beyond);
			int sh;
			longint i, fr, lo, hi, corr;
			sh = span_bits - 6;
			if (a >= (64'sd1 <<< span_bits)) return beyond;
			i = (a >>> sh) & 63;
			fr = a & ((64'sd1 <<< sh) - 1);
			case (which)
				0: begin lo = tanh_pts[i]; hi = tanh_pts[i + 1]; end
				1: begin lo = sig_pts[i]; hi = sig_pts[i + 1]; end
				default: begin lo = exp_pts[i]; hi = exp_pts[i + 1]; end
			endcase
			if (hi >= lo) begin
				corr = ((hi - lo) * fr + (64'sd1 <<< (sh - 1))) >>> sh;
				return lo + corr;
			end
			corr = ((lo - hi) * fr + (64'sd1 <<< (sh - 1))) >>> sh;
			return lo - corr;
		endfunction

		function longint rnd10(longint v);
			longint m;
			m = v < 0 ? -v : v;
			m = (m + 512) >>> 10;
			return v < 0 ? -m : m;
		endfunction

		function longint tanh_fx(longint x);
			longint y;
			y = interp(0, 13, x < 0 ? -x : x, ONE_Q);
			return x < 0 ? -y : y;
		endfunction

		function longint gauss_fx(longint x);
			return interp(2, 24, 36 * x * x, 0);
		endfunction

		function void queue_result(logic signed [15:0] val, bit sat);
			want_val = {want_val, val};
			want_sat = {want_sat, sat};
		endfunction

		function void note(bit op, logic signed [15:0] xin);
			longint x, a, v, s, g, den;
			x = xin;
			a = x < 0 ? -x : x;
			case (kind)
				FK_LINEAR: v = op ? ONE_Q : x;
				FK_TANH: v = op ? rnd10(ONE_SQ - x * x) : tanh_fx(x);
				FK_RELU: v = op ? (x > 0 ? ONE_Q : 0) : (x > 0 ? x : 0);
				FK_SYMM_RELU:
					if (op) v = (a > MARGIN_Q) ? ONE_Q : 0;
					else v = x > MARGIN_Q ? x - MARGIN_Q : (x < -MARGIN_Q ? x + MARGIN_Q : 0);
				FK_TANH_SHIFT:
					v = op ? rnd10((MARGIN_Q <<< 10) + ONE_SQ - x * x) : tanh_fx(x - MARGIN_Q);
				FK_SOFTSIGN:
					if (op) v = rnd10((ONE_Q - a) * (ONE_Q - a));
					else begin
						den = ONE_Q + a;
						v = ((a <<< 11) + den) / (2 * den);
						if (x < 0) v = -v;
					end
				FK_SIGMOID: begin
					s = interp(1, 14, a, ONE_Q);
					if (x < 0) s = ONE_Q - s;
					v = op ? rnd10(s * (ONE_Q - s)) : s;
				end
				FK_GAUSS: begin
					g = gauss_fx(x);
					v = op ? rnd10(-72 * x * g) : g;
				end
				FK_GAUSS_C: begin
					g = ONE_Q - gauss_fx(x);
					v = op ? rnd10(72 * x * g) : g;
				end
				default: v = 0;
			endcase
			if (v > 32767) queue_result(16'sh7fff, 1'b1);
			else if (v < -32768) queue_result(16'sh8000, 1'b1);
			else queue_result(16'(v), 1'b0);
			noted++;
		endfunction

		function void check(logic signed [15:0] val, logic sat);
			logic signed [15:0] ev;
			bit es;
			if (want_val.size() == 0) begin
				$error("unexpected result %0d sat %0b", val, sat);
				errors++;
				return;
			end
			ev = want_val.pop_front();
			es = want_sat.pop_front();
			checked++;
			if (val !== ev) begin
				$error("result_value: expected %0d, actual %0d (kind %0d)", ev, val, kind);
				errors++;
			end
			if (sat !== es) begin
				$error("saturated: expected %0b, actual %0b (kind %0d)", es, sat, kind);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [3:0] cfg_wr_data = 4'd0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic opcode = 1'b0;
	logic signed [15:0] operand_value = 16'sd0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] result_value;
	logic saturated;

	act_scoreboard sb = new();
	bit held_once = 0;

	neural_activation_unit uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .operand_value(operand_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_value(result_value), .saturated(saturated)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check(result_value, saturated);
	end

	// receiver: random back-pressure, one long hold mid-run
	initial begin
		int stall;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held_once && sb.noted >= 300) begin
				held_once = 1;
				out_ready = 1'b0;
				for (int c = 0; c < 300; c++) @(negedge clk);
			end
			if (stall > 0) begin
				stall--;
				out_ready = 1'b0;
			end else if ((sb.noted / 100) % 3 != 2 && $urandom_range(0, 3) == 0) begin
				stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
				out_ready = 1'b0;
			end else
				out_ready = 1'b1;
		end
	end

	task automatic send_req(bit op, logic signed [15:0] x);
		@(negedge clk);
		in_valid = 1'b1;
		opcode = op;
		operand_value = x;
		do @(posedge clk); while (!in_ready);
		sb.note(op, x);
	endtask

	task automatic idle(int n);
		for (int c = 0; c < n; c++) begin
			@(negedge clk);
			in_valid = 1'b0;
			opcode = 1'($urandom);
			operand_value = 16'($urandom);
		end
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		idle(1);
		while (sb.want_val.size() != 0 && guard < 20000) begin
			@(negedge clk);
			guard++;
		end
		idle(10);
	endtask

	task automatic write_kind(logic [3:0] k);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = k;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		sb.kind = k;
	endtask

	function automatic logic signed [15:0] pick_operand();
		case ($urandom_range(0, 5))
			0: return 16'($urandom);
			1: return $signed(16'($urandom_range(0, 1400))) - 16'sd700;
			2: return $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
			3: return $signed(16'($urandom_range(0, 40))) +
				($urandom_range(0, 1) ? 16'sd287 : -16'sd327);
			4: return $signed(16'($urandom_range(0, 33000))) - 16'sd16500;
			default: return $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
		endcase
	endfunction

	initial begin
		logic signed [15:0] edges [12] = '{16'sh8000, 16'sh7fff, 16'sd0, 16'sd1, -16'sd1,
			16'sd307, 16'sd308, -16'sd307, -16'sd308, 16'sd8192, -16'sd16384, 16'sd1024};
		logic [3:0] kinds [$] = '{FK_LINEAR, FK_ZERO, FK_TANH, FK_RELU, FK_SYMM_RELU,
			FK_TANH_SHIFT, FK_SOFTSIGN, FK_SIGMOID, FK_GAUSS, FK_GAUSS_C, 4'd10, 4'd15};
		int nrand;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// directed edges under the reset kind, both opcodes
		for (int i = 0; i < 12; i++) begin
			send_req(1'b0, edges[i]);
			send_req(1'b1, edges[i]);
		end
		drain();
		for (int r = 0; r < 6; r++) kinds = {kinds, 4'($urandom_range(0, 15))};
		foreach (kinds[p]) begin
			write_kind(kinds[p]);
			for (int i = 0; i < 4; i++) send_req(i[0], edges[$urandom_range(0, 11)]);
			nrand = 40;
			for (int i = 0; i < nrand; i++) begin
				send_req(1'($urandom), pick_operand());
				if (i == 20 && p == 3) drain();
				else if ((sb.noted / 100) % 3 != 2 && $urandom_range(0, 3) == 0)
					idle(($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
						: $urandom_range(1, 3));
			end
			drain();
		end
		drain();
		$display("covered %0d requests over %0d kind settings, %0d results checked",
			sb.noted, kinds.size() + 1, sb.checked);
		if (sb.errors == 0 && sb.want_val.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

// File: files.f
hw/rtl/nau_pkg.sv
hw/rtl/neural_activation_unit.sv
dv/neural_activation_unit_test.sv
